/* hw/rtl/cwnd_pkg.sv */
// Shared types and constants for the custom width number decoder.
package cwnd_pkg;
    typedef enum logic [1:0] {
        CFG_ELEMENT_BYTES = 2'd0,
        CFG_LITTLE_ENDIAN = 2'd1,
        CFG_DATA_TYPE     = 2'd2
    } t_cfg_index;

    localparam logic [1:0] DT_SIGNED   = 2'd0;
    localparam logic [1:0] DT_UNSIGNED = 2'd1;
    localparam logic [1:0] DT_FLOAT    = 2'd2;

    localparam logic [63:0] QNAN = 64'h7FF8000000000000;
    localparam logic [63:0] PINF = 64'h7FF0000000000000;

    typedef struct packed {
        logic [1:0] nb_m1;
        logic       little_endian;
        logic [1:0] num_kind;
    } t_cfg;
endpackage

/* hw/rtl/cwnd_cfg.sv */
// Configuration register file.
module cwnd_cfg
    import cwnd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_we,
    input  logic [1:0]  i_index,
    input  logic [31:0] i_data,
    output t_cfg        o_cfg
);
    logic [2:0] r_eb;
    logic       r_le;
    logic [1:0] r_dt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eb <= 3'd1;
            r_le <= 1'b0;
            r_dt <= DT_SIGNED;
        end else if (i_we) begin
            case (i_index)
                CFG_ELEMENT_BYTES: r_eb <= i_data[2:0];
                CFG_LITTLE_ENDIAN: r_le <= i_data[0];
                CFG_DATA_TYPE:     r_dt <= i_data[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_eb == 3'd0) begin
            o_cfg.nb_m1 = 2'd0;
        end else if (r_eb > 3'd4) begin
            o_cfg.nb_m1 = 2'd3;
        end else begin
            o_cfg.nb_m1 = 2'(r_eb - 3'd1);
        end
        o_cfg.little_endian = r_le;
        o_cfg.num_kind      = r_dt;
    end
endmodule

/* hw/rtl/cwnd_conv.sv */
// Combinational element decode: byte order, integer extension and float conversion.
module cwnd_conv
    import cwnd_pkg::*;
(
    input  t_cfg        i_cfg,
    input  logic [31:0] i_raw,
    output logic [63:0] o_result
);
    logic [31:0] v;
    logic [31:0] m;
    logic        sgn;
    logic [9:0]  ex;
    logic [9:0]  emax;
    logic [20:0] frac;
    logic [10:0] bias;
    logic [4:0]  fw;
    logic [4:0]  p;
    logic [10:0] dexp;
    logic [51:0] dfrac;
    logic [63:0] fres;
    logic [20:0] fx;

    always_comb begin
        unique case (i_cfg.nb_m1)
            2'd0: m = 32'h000000FF;
            2'd1: m = 32'h0000FFFF;
            2'd2: m = 32'h00FFFFFF;
            default: m = 32'hFFFFFFFF;
        endcase
        v = i_raw & m;
        if (i_cfg.little_endian) begin
            unique case (i_cfg.nb_m1)
                2'd1: v = {16'd0, v[7:0], v[15:8]};
                2'd2: v = {8'd0, v[7:0], v[15:8], v[23:16]};
                2'd3: v = {v[7:0], v[15:8], v[23:16], v[31:24]};
                default: ;
            endcase
        end
        sgn = 1'b0;
        ex = '0;
        frac = '0;
        dexp = '0;
        dfrac = '0;
        unique case (i_cfg.nb_m1)
            2'd0: begin
                sgn = v[7]; ex = {6'd0, v[6:3]}; frac = {18'd0, v[2:0]};
                emax = 10'h00F; bias = 11'd7; fw = 5'd3;
            end
            2'd1: begin
                sgn = v[15]; ex = {4'd0, v[14:9]}; frac = {12'd0, v[8:0]};
                emax = 10'h03F; bias = 11'd31; fw = 5'd9;
            end
            2'd2: begin
                sgn = v[23]; ex = {2'd0, v[22:15]};
                frac = {6'd0, v[14:3], v[2] | (|v[1:0]), 2'b00};
                emax = 10'h0FF; bias = 11'd127; fw = 5'd15;
            end
            default: begin
                sgn = v[31]; ex = v[30:21];
                frac = {v[20:9], v[8] | (|v[7:0]), 8'd0};
                emax = 10'h3FF; bias = 11'd511; fw = 5'd21;
            end
        endcase
        p = '0;
        for (int k = 0; k < 21; k++) begin
            if (frac[k]) p = 5'(k);
        end
        fx = frac ^ (21'd1 << p);
        if (ex == emax) begin
            fres = (frac != '0) ? QNAN : ({sgn, 63'd0} | PINF);
        end else if (ex == '0) begin
            if (frac == '0) begin
                fres = {sgn, 63'd0};
            end else begin
                dexp = 11'(11'({6'd0, p}) + 11'd1 - bias - 11'({6'd0, fw}) + 11'd1023);
                dfrac = 52'({31'd0, fx} << (6'd52 - {1'b0, p}));
                fres = {sgn, dexp, dfrac};
            end
        end else begin
            dexp = 11'({1'b0, ex} - bias + 11'd1023);
            dfrac = 52'({31'd0, frac} << (6'd52 - {1'b0, fw}));
            fres = {sgn, dexp, dfrac};
        end
        case (i_cfg.num_kind)
            DT_SIGNED: o_result = v[{i_cfg.nb_m1, 3'b111}] ? ({32'd0, v} | ~{32'd0, m})
                                                           : {32'd0, v};
            DT_FLOAT:  o_result = fres;
            default:   o_result = {32'd0, v};
        endcase
    end
endmodule

/* hw/rtl/custom_width_number_decoder_top.sv */
// Top level of the custom width number decoder.
// Input channel i_valid/o_ready carries one raw element (1 to 4 bytes, file
// order) per transaction. Output channel o_valid/i_ready carries one 64-bit
// result per element: sign-extended, zero-extended or binary64 by number kind.
// Configuration channel i_cfg_valid/o_cfg_ready writes element_bytes (0),
// little_endian (1) and the number kind (2); write only while idle.
// An accepted element is loaded into the input register, and the result
// register then loads its converted value once it is empty or being taken,
// with the conversion logic between the two registers.
// Throughput is one element per cycle while the receiver keeps up; the input
// register advances whenever the result register is empty or being taken.
// A stalled receiver holds the result; the pipeline fills and then o_ready
// drops until the receiver takes a result.
// Reset empties both registers and restores the configuration defaults.
module custom_width_number_decoder_top
    import cwnd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_raw_element,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_result_bits,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    t_cfg        cfg;
    logic        r_in_vld;
    logic [31:0] r_in;
    logic        r_out_vld;
    logic [63:0] r_out;
    logic [63:0] n_out;
    logic        adv;

    assign o_cfg_ready = 1'b1;

    cwnd_cfg u_cfg (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_we(i_cfg_valid),
        .i_index(i_cfg_index), .i_data(i_cfg_data), .o_cfg(cfg)
    );

    cwnd_conv u_conv (.i_cfg(cfg), .i_raw(r_in), .o_result(n_out));

    assign adv     = !r_out_vld || i_ready;
    assign o_ready = !r_in_vld || adv;
    assign o_valid = r_out_vld;
    assign o_result_bits = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_ready) r_in_vld <= i_valid;
            if (adv) r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) r_in <= i_raw_element;
        if (adv && r_in_vld) r_out <= n_out;
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !i_ready |=> r_out_vld && $stable(r_out)) else $error("result lost");
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && r_out_vld && !i_ready |-> !o_ready) else $error("overrun");
    a_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && adv |=> r_out_vld) else $error("item dropped");
endmodule
